// ----- hw/rtl/indexed_min_heap_timer_queue_assert.svh -----
// ----------------------------------------------------------------------------
// timer queue assertion macros
// concurrent checks on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TQ_ASSERT_IMP(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("timer queue check failed");
// next-cycle implication
`define TQ_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("timer queue check failed");
`else
`define TQ_ASSERT_IMP(lbl, ant, con)
`define TQ_ASSERT_NXT(lbl, ant, con)
`endif

`endif

// ----- hw/rtl/tq_pkg.sv -----
// ----------------------------------------------------------------------------
// tq_pkg
// shared sizes, command codes and helpers of the heap timer queue
// ----------------------------------------------------------------------------
package tq_pkg;

	localparam int HEAP_DEPTH = 32;
	localparam int ID_SPACE   = 1024;
	localparam int TIME_W     = 32;
	localparam int WAIT_W     = 30;
	localparam int FIFO_DEPTH = 4;

	localparam int SLOT_W = $clog2(HEAP_DEPTH);
	localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
	localparam int ID_W   = $clog2(ID_SPACE);

	// raw action field codes
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_ADJ = 3'd1;
	localparam logic [2:0] ACT_REM = 3'd2;
	localparam logic [2:0] ACT_EXP = 3'd3;
	localparam logic [2:0] ACT_NXT = 3'd4;

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_EXP = 2'd1;
	localparam logic [1:0] KIND_NXT = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

	typedef enum logic [2:0] {
		OP_ADD,
		OP_ADJ,
		OP_REM,
		OP_EXP,
		OP_NXT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [TIME_W-1:0] expiry;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             busy;
	} stat_t;

	// wrap-aware: a is earlier than b
	function automatic logic t_before(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

endpackage

// ----- hw/rtl/tq_if.sv -----
// ----------------------------------------------------------------------------
// tq_if
// request and result channels of the heap timer queue
// ----------------------------------------------------------------------------
interface tq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [9:0]  timer_id;
	logic [29:0] delay_ms;
	logic [31:0] now_ms;
	modport source(output valid, action, timer_id, delay_ms, now_ms, input ready);
	modport sink(input valid, action, timer_id, delay_ms, now_ms, output ready);
endinterface

interface tq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [9:0]  expired_id;
	logic [29:0] wait_ms;
	logic        queue_empty;
	logic        last;
	modport source(output valid, kind, status, expired_id, wait_ms, queue_empty, last,
		input ready);
	modport sink(input valid, kind, status, expired_id, wait_ms, queue_empty, last,
		output ready);
endinterface

// ----- hw/rtl/tq_front.sv -----
// ----------------------------------------------------------------------------
// tq_front
// takes requests, decodes the action and forms the absolute expiry
// ----------------------------------------------------------------------------
module tq_front (
	input  logic         clk,
	input  logic         arst_n,
	tq_req_if.sink       req,
	output tq_pkg::cmd_t cmd,
	output logic         cmd_valid,
	input  logic         cmd_ready
);
	import tq_pkg::*;

	cmd_t cmd_s1;
	cmd_t cmd_nxt;
	logic vld_s1;

	assign req.ready = !vld_s1 || cmd_ready;
	assign cmd       = cmd_s1;
	assign cmd_valid = vld_s1;

	always_comb begin
		unique case (req.action)
			ACT_ADD: cmd_nxt.op = OP_ADD;
			ACT_ADJ: cmd_nxt.op = OP_ADJ;
			ACT_REM: cmd_nxt.op = OP_REM;
			ACT_EXP: cmd_nxt.op = OP_EXP;
			ACT_NXT: cmd_nxt.op = OP_NXT;
			default: cmd_nxt.op = OP_NOP;
		endcase
		cmd_nxt.id     = req.timer_id[ID_W-1:0];
		cmd_nxt.now    = req.now_ms[TIME_W-1:0];
		cmd_nxt.expiry = req.now_ms[TIME_W-1:0] + TIME_W'(req.delay_ms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cmd_nxt;
		end
	end

endmodule

// ----- hw/rtl/tq_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tq_cmd_fifo
// short command queue between the front and the heap engine
// ----------------------------------------------------------------------------
module tq_cmd_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tq_pkg::cmd_t in_cmd,
	output logic         out_valid,
	input  logic         out_ready,
	output tq_pkg::cmd_t out_cmd
);
	import tq_pkg::*;

	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             q_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [FILL_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = fill_q != FILL_W'(FIFO_DEPTH);
	assign out_valid = fill_q != '0;
	assign out_cmd   = q_mem[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop) rd_q <= bump(rd_q);
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= in_cmd;
		end
	end

endmodule

// ----- hw/rtl/tq_back.sv -----
// ----------------------------------------------------------------------------
// tq_back
// heap engine: slot lookup, sift up and down with a hole, expiry scan
// ----------------------------------------------------------------------------
module tq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tq_pkg::cmd_t  cmd,
	tq_rsp_if.source      rsp,
	output tq_pkg::stat_t stat
);
	import tq_pkg::*;

	localparam int IX_W = SLOT_W + 2;
	localparam int HW   = TIME_W + ID_W;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK1, S_LOOK2, S_DROP_RD, S_DROP_LD,
		S_SINK_A, S_SINK_B, S_SINK_C, S_SINK_D,
		S_RISE_A, S_RISE_B, S_PLACE, S_FIRE_CHK, S_FIRE_EV, S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        status;
		logic [ID_W-1:0]   id;
		logic [WAIT_W-1:0] wait_ms;
		logic              empty;
		logic              last;
	} res_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [1:0] status,
		input logic [ID_W-1:0] id, input logic [WAIT_W-1:0] w, input logic empty,
		input logic last);
		res_t r;
		r.kind    = kind;
		r.status  = status;
		r.id      = id;
		r.wait_ms = w;
		r.empty   = empty;
		r.last    = last;
		return r;
	endfunction

	// heap slots {expiry, owner} and id to slot map
	logic [HW-1:0]     heap_mem [HEAP_DEPTH];
	logic [SLOT_W-1:0] map_mem [ID_SPACE];
	logic [HW-1:0]     heap_rd_q;
	logic [SLOT_W-1:0] map_rd_q;

	logic [SLOT_W-1:0] heap_ra, heap_wa, map_wd;
	logic [HW-1:0]     heap_wd;
	logic              heap_we, map_we;
	logic [ID_W-1:0]   map_ra, map_wa;

	state_t            state_q, nxt_q;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] i_q, start_q, slot_q, ch_idx_q;
	logic              slot_ok_q;
	logic [TIME_W-1:0] mov_exp_q, ch_exp_q;
	logic [ID_W-1:0]   mov_own_q, ch_own_q;
	res_t              res_q, out_q;
	logic              out_valid_q;

	logic [TIME_W-1:0] rd_exp;
	logic [ID_W-1:0]   rd_own;
	logic [IX_W-1:0]   c_idx, c1_idx, cnt_x;
	logic [SLOT_W-1:0] p_idx;
	logic [TIME_W-1:0] due_d;
	logic              c_in, c1_in, present, can_emit, fire_op, emit_go;

	assign rd_exp   = heap_rd_q[HW-1:ID_W];
	assign rd_own   = heap_rd_q[ID_W-1:0];
	assign c_idx    = {1'b0, i_q, 1'b1};
	assign c1_idx   = c_idx + 1'b1;
	assign cnt_x    = IX_W'(cnt_q);
	assign c_in     = c_idx < cnt_x;
	assign c1_in    = c1_idx < cnt_x;
	assign p_idx    = (i_q - 1'b1) >> 1;
	assign due_d    = rd_exp - cmd_q.now;
	assign present  = slot_ok_q && (rd_own == cmd_q.id);
	assign can_emit = !out_valid_q || rsp.ready;
	assign emit_go  = (state_q == S_EMIT) && can_emit;
	assign fire_op  = (cmd_q.op == OP_EXP) || (cmd_q.op == OP_NXT);

	assign cmd_ready = state_q == S_IDLE;
	assign stat.cnt  = cnt_q;
	assign stat.busy = (state_q != S_IDLE) || out_valid_q;

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_q.kind;
	assign rsp.status      = out_q.status;
	assign rsp.expired_id  = out_q.id;
	assign rsp.wait_ms     = out_q.wait_ms;
	assign rsp.queue_empty = out_q.empty;
	assign rsp.last        = out_q.last;

	always_comb begin
		heap_ra = '0;
		heap_we = 1'b0;
		heap_wa = i_q;
		heap_wd = {ch_exp_q, ch_own_q};
		map_ra  = cmd.id;
		map_we  = 1'b0;
		map_wa  = ch_own_q;
		map_wd  = i_q;
		unique case (state_q)
			S_LOOK1:   heap_ra = map_rd_q;
			S_DROP_RD: heap_ra = cnt_q[SLOT_W-1:0];
			S_SINK_A:  heap_ra = c_idx[SLOT_W-1:0];
			S_SINK_B:  heap_ra = c1_idx[SLOT_W-1:0];
			S_SINK_D: begin
				if (t_before(ch_exp_q, mov_exp_q)) begin
					heap_we = 1'b1;
					map_we  = 1'b1;
				end
			end
			S_RISE_A:  heap_ra = p_idx;
			S_RISE_B: begin
				// parent moves down into the hole
				if (t_before(mov_exp_q, rd_exp)) begin
					heap_we = 1'b1;
					heap_wd = heap_rd_q;
					map_we  = 1'b1;
					map_wa  = rd_own;
				end
			end
			S_PLACE: begin
				heap_we = 1'b1;
				heap_wd = {mov_exp_q, mov_own_q};
				map_we  = 1'b1;
				map_wa  = mov_own_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		heap_rd_q <= heap_mem[heap_ra];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						unique case (cmd.op)
							OP_ADD, OP_ADJ, OP_REM: state_q <= S_LOOK1;
							OP_EXP, OP_NXT:         state_q <= S_FIRE_CHK;
							default: begin
								res_q   <= mk_res(KIND_ACK, ST_OK, '0, '0, 1'b0, 1'b1);
								nxt_q   <= S_IDLE;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_LOOK1: begin
					slot_q    <= map_rd_q;
					slot_ok_q <= CNT_W'(map_rd_q) < cnt_q;
					state_q   <= S_LOOK2;
				end
				S_LOOK2: begin
					nxt_q <= S_IDLE;
					res_q <= mk_res(KIND_ACK, ST_OK, '0, '0, 1'b0, 1'b1);
					if (present && (cmd_q.op == OP_ADD || cmd_q.op == OP_ADJ)) begin
						// re-time in place
						i_q       <= slot_q;
						start_q   <= slot_q;
						mov_exp_q <= cmd_q.expiry;
						mov_own_q <= cmd_q.id;
						state_q   <= S_SINK_A;
					end else if (present && cmd_q.op == OP_REM) begin
						cnt_q   <= cnt_q - 1'b1;
						i_q     <= slot_q;
						start_q <= slot_q;
						if (CNT_W'(slot_q) == cnt_q - 1'b1) state_q <= S_EMIT;
						else state_q <= S_DROP_RD;
					end else if (cmd_q.op == OP_ADD) begin
						if (cnt_q == CNT_W'(HEAP_DEPTH)) begin
							res_q   <= mk_res(KIND_ACK, ST_FULL, '0, '0, 1'b0, 1'b1);
							state_q <= S_EMIT;
						end else begin
							i_q       <= cnt_q[SLOT_W-1:0];
							cnt_q     <= cnt_q + 1'b1;
							mov_exp_q <= cmd_q.expiry;
							mov_own_q <= cmd_q.id;
							state_q   <= S_RISE_A;
						end
					end else begin
						res_q   <= mk_res(KIND_ACK, ST_ABSENT, '0, '0, 1'b0, 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_DROP_RD: state_q <= S_DROP_LD;
				S_DROP_LD: begin
					// last slot fills the hole
					mov_exp_q <= rd_exp;
					mov_own_q <= rd_own;
					state_q   <= S_SINK_A;
				end
				S_SINK_A: begin
					if (c_in) state_q <= S_SINK_B;
					else if (i_q == start_q) state_q <= S_RISE_A;
					else state_q <= S_PLACE;
				end
				S_SINK_B: begin
					ch_exp_q <= rd_exp;
					ch_own_q <= rd_own;
					ch_idx_q <= c_idx[SLOT_W-1:0];
					state_q  <= c1_in ? S_SINK_C : S_SINK_D;
				end
				S_SINK_C: begin
					if (t_before(rd_exp, ch_exp_q)) begin
						ch_exp_q <= rd_exp;
						ch_own_q <= rd_own;
						ch_idx_q <= c1_idx[SLOT_W-1:0];
					end
					state_q <= S_SINK_D;
				end
				S_SINK_D: begin
					if (t_before(ch_exp_q, mov_exp_q)) begin
						i_q     <= ch_idx_q;
						state_q <= S_SINK_A;
					end else if (i_q == start_q) begin
						state_q <= S_RISE_A;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_RISE_A: state_q <= (i_q == '0) ? S_PLACE : S_RISE_B;
				S_RISE_B: begin
					if (t_before(mov_exp_q, rd_exp)) begin
						i_q     <= p_idx;
						state_q <= S_RISE_A;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (fire_op) begin
						state_q <= S_FIRE_CHK;
					end else begin
						res_q   <= mk_res(KIND_ACK, ST_OK, '0, '0, 1'b0, 1'b1);
						nxt_q   <= S_IDLE;
						state_q <= S_EMIT;
					end
				end
				S_FIRE_CHK: begin
					if (cnt_q == '0) begin
						if (cmd_q.op == OP_EXP)
							res_q <= mk_res(KIND_ACK, ST_OK, '0, '0, 1'b0, 1'b1);
						else
							res_q <= mk_res(KIND_NXT, ST_OK, '0, '0, 1'b1, 1'b1);
						nxt_q   <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_FIRE_EV;
					end
				end
				S_FIRE_EV: begin
					state_q <= S_EMIT;
					if (due_d == '0 || due_d[TIME_W-1]) begin
						res_q   <= mk_res(KIND_EXP, ST_OK, rd_own, '0, 1'b0, 1'b0);
						cnt_q   <= cnt_q - 1'b1;
						i_q     <= '0;
						start_q <= '0;
						nxt_q   <= (cnt_q == CNT_W'(1)) ? S_FIRE_CHK : S_DROP_RD;
					end else begin
						nxt_q <= S_IDLE;
						if (cmd_q.op == OP_EXP)
							res_q <= mk_res(KIND_ACK, ST_OK, '0, '0, 1'b0, 1'b1);
						else if (due_d > TIME_W'(WAIT_MAX))
							res_q <= mk_res(KIND_NXT, ST_OK, '0, WAIT_MAX, 1'b0, 1'b1);
						else
							res_q <= mk_res(KIND_NXT, ST_OK, '0, due_d[WAIT_W-1:0],
								1'b0, 1'b1);
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_q   <= res_q;
						state_q <= nxt_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/indexed_min_heap_timer_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue: the result of an absent-id request comes after its lookup, that of an
// add, re-time or removal after its lookup and sifting, which may cover every level of the heap;
// one request in the engine at a time, each fired id adds its own result, root refill and sifting
// asynchronous reset empties the heap at once, no clearing pass
// ----------------------------------------------------------------------------
`include "indexed_min_heap_timer_queue_assert.svh"

module indexed_min_heap_timer_queue (
	input  logic     clk,
	input  logic     arst_n,
	tq_req_if.sink   req,
	tq_rsp_if.source rsp
);
	import tq_pkg::*;

	cmd_t  fr_cmd, q_cmd;
	logic  fr_valid, fr_ready, q_valid, q_ready;
	stat_t stat;

	tq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (fr_cmd),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready)
	);

	tq_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	tq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.rsp       (rsp),
		.stat      (stat)
	);

	`TQ_ASSERT_IMP(a_cnt_range, 1'b1, stat.cnt <= CNT_W'(HEAP_DEPTH))
	`TQ_ASSERT_IMP(a_exp_not_last, rsp.valid && rsp.kind == KIND_EXP, !rsp.last)
	`TQ_ASSERT_IMP(a_nxt_last, rsp.valid && rsp.kind == KIND_NXT, rsp.last)
	`TQ_ASSERT_IMP(a_idle_quiet, !stat.busy, !rsp.valid)

endmodule
